// ===== hw/rtl/sgm_path_cost_aggregator_unit_defines.svh =====
`ifndef SGM_PATH_COST_AGGREGATOR_UNIT_DEFINES_SVH
`define SGM_PATH_COST_AGGREGATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SGM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgm assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgm assertion failed");

`endif

// ===== hw/rtl/sgm_pca_pkg.sv =====
package sgm_pca_pkg;

  localparam int DISPARITIES = 64;
  localparam int DISP_W      = $clog2(DISPARITIES);
  localparam int COST_W      = 8;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [COST_W-1:0] COST_MAX = 8'hFF;

  localparam logic [COST_W-1:0] SMALL_PENALTY_RST = 8'd10;
  localparam logic [COST_W-1:0] LARGE_PENALTY_RST = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMALL_PENALTY = 1'b0,
    CFG_LARGE_PENALTY = 1'b1
  } cfg_reg_t;

endpackage

// ===== hw/rtl/sgm_path_cost_aggregator_unit.sv =====
// path: an accepted item goes into the input register, then the result register drives result valid
// throughput: one item per cycle while out_ready does not stall, set by the combinational cost update and one
//   memory write plus one look-ahead read of the previous cost vector per item
// reset: synchronous active-low rst_n clears handshake and counter, resets minima, restores default penalties;
//   the previous cost vector is undefined until the first path start fills it
`include "sgm_path_cost_aggregator_unit_defines.svh"

module sgm_path_cost_aggregator_unit
  import sgm_pca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COST_W-1:0]    in_match_cost,
  input  logic                 in_path_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COST_W-1:0]    out_path_cost,
  output logic [IDX_W-1:0]     out_disparity_index,
  output logic                 out_last_disparity,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_wdata
);

  localparam logic [DISP_W-1:0] LAST_D = DISP_W'(DISPARITIES - 1);
  localparam logic [DISP_W-1:0] PENU_D = DISP_W'(DISPARITIES - 2);

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min_c(input logic [COST_W-1:0] a,
                                             input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic [COST_W-1:0] mem [DISPARITIES];

  logic [COST_W-1:0] small_penalty_r, large_penalty_r;
  logic              s1_valid_r;
  logic [COST_W-1:0] s1_cost_r;
  logic              s1_start_r;
  logic [DISP_W-1:0] cnt_r, cnt_nxt;
  logic [COST_W-1:0] own_r, up_r;
  logic [COST_W-1:0] prev_min_r, run_min_r, run_min_nxt;
  logic [COST_W-1:0] held_lower_r;
  logic              start_held_r;
  logic              out_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  logic              adv;
  logic              is_first, is_last, start_eff;
  logic [COST_W-1:0] lower, upper, m, diff, result;
  logic [DISP_W-1:0] rd_addr;
  logic [8:0]        cnt_ext;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign is_first  = (cnt_r == '0);
  assign is_last   = (cnt_r == LAST_D);
  assign start_eff = is_first ? s1_start_r : start_held_r;
  assign cnt_ext   = 9'(cnt_r);

  always_comb begin
    lower  = is_first ? COST_MAX : held_lower_r;
    upper  = is_last ? COST_MAX : up_r;
    m      = own_r;
    m      = min_c(m, sat_add(lower, small_penalty_r));
    m      = min_c(m, sat_add(upper, small_penalty_r));
    m      = min_c(m, sat_add(prev_min_r, large_penalty_r));
    diff   = (m >= prev_min_r) ? (m - prev_min_r) : '0;
    result = start_eff ? s1_cost_r : sat_add(s1_cost_r, diff);

    run_min_nxt = is_first ? result : min_c(run_min_r, result);
    cnt_nxt     = is_last ? '0 : cnt_r + DISP_W'(1);

    // look-ahead read for the entry after the next one
    if (is_last) begin
      rd_addr = DISP_W'(1);
    end else if (cnt_r == PENU_D) begin
      rd_addr = '0;
    end else begin
      rd_addr = cnt_r + DISP_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_penalty_r <= SMALL_PENALTY_RST;
      large_penalty_r <= LARGE_PENALTY_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SMALL_PENALTY: small_penalty_r <= cfg_wdata;
        CFG_LARGE_PENALTY: large_penalty_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      prev_min_r   <= '0;
      run_min_r    <= COST_MAX;
      held_lower_r <= COST_MAX;
      start_held_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv) begin
        cnt_r        <= cnt_nxt;
        held_lower_r <= own_r;
        start_held_r <= start_eff;
        if (is_last) begin
          prev_min_r <= run_min_nxt;
          run_min_r  <= COST_MAX;
        end else begin
          run_min_r <= run_min_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cost_r  <= in_match_cost;
      s1_start_r <= in_path_start;
    end
    if (adv) begin
      out_cost_r <= result;
      out_idx_r  <= cnt_ext[IDX_W-1:0];
      out_last_r <= is_last;
      own_r      <= up_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem[cnt_r] <= result;
      up_r       <= mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_path_cost       = out_cost_r;
  assign out_disparity_index = out_idx_r;
  assign out_last_disparity  = out_last_r;

  `SGM_ASSERT_NOW(a_last_idx, out_valid && out_last_disparity, out_disparity_index == cnt_ext[IDX_W-1:0] || cnt_r == '0)
  `SGM_ASSERT_NEXT(a_cnt_wrap, adv && is_last, cnt_r == '0 && run_min_r == COST_MAX)
  `SGM_ASSERT_NEXT(a_start_raw, adv && start_eff, out_valid && out_path_cost == $past(s1_cost_r))
  `SGM_ASSERT_NEXT(a_min_upd, adv && is_last, prev_min_r <= $past(result))

endmodule

// ===== test/sgm_path_cost_checker.sv =====
module sgm_path_cost_checker
  import sgm_pca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [COST_W-1:0]    in_match_cost,
  input  logic                 in_path_start,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [COST_W-1:0]    out_path_cost,
  input  logic [IDX_W-1:0]     out_disparity_index,
  input  logic                 out_last_disparity,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_wdata,
  output int                   outstanding,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } path_result_t;

  logic [COST_W-1:0] prev_cost [DISPARITIES];
  logic [COST_W-1:0] prev_min;
  logic [COST_W-1:0] run_min;
  logic [COST_W-1:0] lower_held;
  logic [COST_W-1:0] small_pen;
  logic [COST_W-1:0] large_pen;
  int                disp;
  logic              start_held;

  path_result_t      expected_costs [$];
  int                errors = 0;

  function automatic logic [COST_W-1:0] sat_sum(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min_cost(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // advances the path state by one disparity and returns the aggregated cost
  function automatic path_result_t aggregate_cost(input logic [COST_W-1:0] cost,
                                                  input logic start);
    int                d;
    logic [COST_W-1:0] own;
    logic [COST_W-1:0] upper;
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] res;
    path_result_t      r;
    d = disp;
    if (d == 0) begin
      start_held = start;
      lower_held = COST_MAX;
    end
    own = prev_cost[d];
    if (start_held) begin
      res = cost;
    end else begin
      upper = (d == DISPARITIES - 1) ? COST_MAX : prev_cost[d + 1];
      best  = own;
      best  = min_cost(best, sat_sum(lower_held, small_pen));
      best  = min_cost(best, sat_sum(upper, small_pen));
      best  = min_cost(best, sat_sum(prev_min, large_pen));
      best  = (best >= prev_min) ? best - prev_min : '0;
      res   = sat_sum(cost, best);
    end
    lower_held = own;
    prev_cost[d] = res;
    run_min = (d == 0) ? res : min_cost(run_min, res);
    r.cost = res;
    r.idx  = d[IDX_W-1:0];
    r.last = (d == DISPARITIES - 1);
    if (r.last) begin
      prev_min = run_min;
      run_min  = COST_MAX;
      disp     = 0;
    end else begin
      disp = d + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    path_result_t got;
    path_result_t exp_r;
    if (!rst_n) begin
      prev_min   = '0;
      run_min    = COST_MAX;
      lower_held = COST_MAX;
      disp       = 0;
      start_held = 1'b0;
      small_pen  = SMALL_PENALTY_RST;
      large_pen  = LARGE_PENALTY_RST;
      expected_costs.delete();
    end else begin
      if (cfg_write_en === 1'b1) begin
        case (cfg_index)
          CFG_SMALL_PENALTY: small_pen = cfg_wdata;
          CFG_LARGE_PENALTY: large_pen = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.cost = out_path_cost;
        got.idx  = out_disparity_index;
        got.last = out_last_disparity;
        if (expected_costs.size() == 0) begin
          $display("%0t unexpected item: expected none, got cost %0d disparity %0d last %0b",
                   $time, got.cost, got.idx, got.last);
          errors++;
        end else begin
          exp_r = expected_costs.pop_front();
          if (got.cost !== exp_r.cost) begin
            $display("%0t path_cost at disparity %0d: expected %0d, got %0d",
                     $time, exp_r.idx, exp_r.cost, got.cost);
            errors++;
          end
          if (got.idx !== exp_r.idx) begin
            $display("%0t disparity_index: expected %0d, got %0d",
                     $time, exp_r.idx, got.idx);
            errors++;
          end
          if (got.last !== exp_r.last) begin
            $display("%0t last_disparity at disparity %0d: expected %0b, got %0b",
                     $time, exp_r.idx, exp_r.last, got.last);
            errors++;
          end
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_costs.push_back(aggregate_cost(in_match_cost, in_path_start));
    end
    outstanding <= expected_costs.size();
    fail_count  <= errors;
  end

endmodule

// ===== test/tb_sgm_path_cost_aggregator_unit.sv =====
module tb_sgm_path_cost_aggregator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pca_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int LATENCY      = 2;
  localparam int DRAIN_CYCLES = 8;
  localparam int BURST_MAX    = 18;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 2;

  localparam logic [COST_W-1:0] SMALL_PLAN [PHASES] = '{0, 255, 0, 255, 1, 10, 0, 0};
  localparam logic [COST_W-1:0] LARGE_PLAN [PHASES] = '{0, 255, 255, 0, 2, 120, 0, 0};

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_QUIET,
    SHAPE_RAMP,
    SHAPE_EXTREME,
    SHAPE_VALLEY
  } cost_shape_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [COST_W-1:0]    in_match_cost;
  logic                 in_path_start;
  logic                 out_valid;
  logic                 out_ready;
  logic [COST_W-1:0]    out_path_cost;
  logic [IDX_W-1:0]     out_disparity_index;
  logic                 out_last_disparity;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COST_W-1:0]    cfg_wdata;

  int outstanding;
  int fail_count;
  bit calm       = 1'b0;
  int gap_odds   = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int cycles     = 0;

  sgm_path_cost_aggregator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_match_cost       (in_match_cost),
    .in_path_start       (in_path_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_path_cost       (out_path_cost),
    .out_disparity_index (out_disparity_index),
    .out_last_disparity  (out_last_disparity),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  sgm_path_cost_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_match_cost       (in_match_cost),
    .in_path_start       (in_path_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_path_cost       (out_path_cost),
    .out_disparity_index (out_disparity_index),
    .out_last_disparity  (out_last_disparity),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .outstanding         (outstanding),
    .fail_count          (fail_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds * 4) == 1) begin
      stall_left <= $urandom_range(0, BURST_MAX - 1);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [COST_W-1:0] cost, input logic start);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds * 4) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_match_cost <= cost;
    in_path_start <= start;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // one pixel: every disparity in order, stray path starts off disparity zero
  task automatic send_pixel(input cost_shape_t shape, input logic start);
    logic [COST_W-1:0] costs [DISPARITIES];
    int level;
    int centre;
    int variant;
    int spread;
    level   = $urandom_range(0, 255);
    centre  = $urandom_range(0, DISPARITIES - 1);
    variant = $urandom_range(0, 3);
    for (int d = 0; d < DISPARITIES; d++) begin
      case (shape)
        SHAPE_NOISE: costs[d] = COST_W'($urandom_range(0, 255));
        SHAPE_QUIET: costs[d] = ($urandom_range(0, 15) == 0) ? COST_MAX
                                                             : COST_W'($urandom_range(0, 15));
        SHAPE_RAMP: begin
          level = level + $urandom_range(0, 2) - 1;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          costs[d] = COST_W'(level);
        end
        SHAPE_EXTREME: begin
          case (variant)
            0: costs[d] = '0;
            1: costs[d] = COST_MAX;
            2: costs[d] = (d % 2 != 0) ? COST_MAX : '0;
            default: costs[d] = (d == 0 || d == DISPARITIES - 1) ? '0 : COST_MAX;
          endcase
        end
        default: begin
          spread = (d > centre) ? d - centre : centre - d;
          spread = spread * (variant + 1) * 4;
          costs[d] = (spread > 255) ? COST_MAX : COST_W'(spread);
        end
      endcase
    end
    for (int d = 0; d < DISPARITIES; d++)
      send_item(costs[d], (d == 0) ? start : 1'($urandom_range(0, 1)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    cost_shape_t shape;
    logic        start;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_match_cost = '0;
    in_path_start = 1'b0;
    cfg_write_en  = 1'b0;
    cfg_index     = CFG_SMALL_PENALTY;
    cfg_wdata     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset penalties, a path start fills the vector before anything reads it
    send_pixel(SHAPE_EXTREME, 1'b1);
    send_pixel(SHAPE_VALLEY, 1'b0);
    send_pixel(SHAPE_EXTREME, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      cfg_write_en <= 1'b1;
      cfg_index    <= CFG_SMALL_PENALTY;
      cfg_wdata    <= (p >= PHASES - 2) ? COST_W'($urandom_range(0, 255)) : SMALL_PLAN[p];
      @(posedge clk);
      cfg_index    <= CFG_LARGE_PENALTY;
      cfg_wdata    <= (p >= PHASES - 2) ? COST_W'($urandom_range(0, 255)) : LARGE_PLAN[p];
      @(posedge clk);
      cfg_write_en <= 1'b0;
      calm       = (p == PHASES - 1);
      gap_odds   = $urandom_range(0, 3);
      stall_odds = $urandom_range(0, 3);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        shape = cost_shape_t'($urandom_range(SHAPE_NOISE, SHAPE_VALLEY));
        start = ($urandom_range(0, 5) == 0);
        send_pixel(shape, start);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
